### hdl/wvq_pkg.sv
// Shared types, widths and constants for the weighted nearest-codeword search.
// No dependencies; used by wvq_cell, wvq_mac and weighted_vq_nearest_codeword.
package wvq_pkg;

    localparam int MAX_CODEWORDS = 32;
    localparam int DIMENSIONS    = 12;
    localparam int COEFF_W       = 16;

    localparam int CW_W     = $clog2(MAX_CODEWORDS);
    localparam int DIM_W    = 4;
    localparam int ACT_W    = 6;
    localparam int ADDR_W   = $clog2(MAX_CODEWORDS * DIMENSIONS);
    localparam int WEIGHT_W = 6;
    localparam int MAG_W    = COEFF_W;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int ACC_W    = 41;

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 48;

    // request kinds carried on s_tuser
    localparam logic REQ_CODEBOOK = 1'b0;
    localparam logic REQ_FEATURE  = 1'b1;

    // configuration register index
    localparam int REG_ACTIVE_CODEWORDS = 0;

    // per-codeword tag that travels down the datapath with each term
    typedef struct packed {
        logic            valid;
        logic [CW_W-1:0] k;
        logic            in_range;
        logic            term_en;
    } wvq_tag_t;

    // fixed per-dimension weights; dimensions past the table use the last one
    function automatic logic [WEIGHT_W-1:0] dim_weight(input logic [DIM_W-1:0] dim);
        logic [WEIGHT_W-1:0] w;
        case (dim)
            4'd0:    w = 6'd1;
            4'd1:    w = 6'd3;
            4'd2:    w = 6'd7;
            4'd3:    w = 6'd13;
            4'd4:    w = 6'd19;
            4'd5:    w = 6'd22;
            4'd6:    w = 6'd25;
            4'd7:    w = 6'd33;
            4'd8:    w = 6'd42;
            4'd9:    w = 6'd50;
            4'd10:   w = 6'd56;
            default: w = 6'd61;
        endcase
        return w;
    endfunction

endpackage

### hdl/wvq_cell.sv
// One accumulator cell of the rotating distance ring.
// Depends on wvq_pkg for the accumulator width.
module wvq_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      shift_en,
    input  logic [wvq_pkg::ACC_W-1:0] acc_in,
    output logic [wvq_pkg::ACC_W-1:0] acc_out
);

    logic [wvq_pkg::ACC_W-1:0] acc_reg;
    logic [wvq_pkg::ACC_W-1:0] acc_next;

    // take the neighbour's value on every ring step
    always_comb begin
        acc_next = shift_en ? acc_in : acc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

    assign acc_out = acc_reg;

endmodule

### hdl/wvq_mac.sv
// Three-stage weighted squared-difference unit: |c - f|, square, times weight.
// Depends on wvq_pkg for widths and the wvq_tag_t tag.
module wvq_mac (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  wvq_pkg::wvq_tag_t            tag_in,
    input  logic [wvq_pkg::COEFF_W-1:0]  coeff,
    input  logic [wvq_pkg::COEFF_W-1:0]  feat,
    input  logic [wvq_pkg::WEIGHT_W-1:0] weight,
    output wvq_pkg::wvq_tag_t            tag_out,
    output logic [wvq_pkg::ACC_W-1:0]    term,
    output logic                         busy
);

    localparam int CW = wvq_pkg::COEFF_W;

    wvq_pkg::wvq_tag_t             tag2_reg, tag3_reg, tag4_reg;
    logic [wvq_pkg::MAG_W-1:0]     mag_reg,  mag_next;
    logic [wvq_pkg::SQ_W-1:0]      sq_reg,   sq_next;
    logic [wvq_pkg::ACC_W-1:0]     term_reg, term_next;
    logic signed [CW:0]            diff;
    logic signed [CW:0]            diff_neg;
    logic [wvq_pkg::SQ_W+wvq_pkg::WEIGHT_W-1:0] prod;

    // stage 2: magnitude of the signed difference
    always_comb begin
        diff     = $signed({coeff[CW-1], coeff}) - $signed({feat[CW-1], feat});
        diff_neg = -diff;
        mag_next = diff[CW] ? diff_neg[CW-1:0] : diff[CW-1:0];
    end

    // stage 3: square; stage 4: weight, zeroed for slots without term_en
    always_comb begin
        sq_next   = mag_reg * mag_reg;
        prod      = sq_reg * weight;
        term_next = tag3_reg.term_en ? wvq_pkg::ACC_W'(prod) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
        end else begin
            tag2_reg <= tag_in;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
        end
        mag_reg  <= mag_next;
        sq_reg   <= sq_next;
        term_reg <= term_next;
    end

    assign tag_out = tag4_reg;
    assign term    = term_reg;
    assign busy    = tag2_reg.valid | tag3_reg.valid | tag4_reg.valid;

endmodule

### hdl/weighted_vq_nearest_codeword.sv
// Top level of the weighted nearest-codeword search: codebook memory, sequencer,
// accumulator ring of wvq_cell, search and output register. Uses wvq_pkg, wvq_mac.
//
// Usage:
//  Input stream (s_*): s_tuser selects a codebook write or a feature element;
//  s_tdata carries codeword index, dimension and Q7.8 value; s_tlast marks the
//  final feature element of a vector. Result stream (m_*): nearest index and
//  unsigned Q25.16 weighted distance, one result per vector.
//  APB register 0 (active_codewords) sets how many codewords are searched.
//  Throughput: codebook writes are taken back to back. A feature element runs a
//  pass over all MAX_CODEWORDS codewords before the next request is taken: the
//  sequencer reads one codeword a cycle from the codebook memory (one write port,
//  one read port) and the accumulator ring steps once per codeword, behind a
//  memory read stage and three datapath stages. After the last element's pass, the
//  result waits in a pending register until the output register is free; m_tvalid
//  then rises in the same cycle that s_tready returns. s_tready drops only while
//  a pass runs, a result is pending or aresetn is low.
//  Reset clears the accumulators, the control state and sets active_codewords
//  to 32. The codebook is undefined until written; no clearing pass is run.
//  Accumulators saturate and are cleared by the pass that gives a result.
module weighted_vq_nearest_codeword (
    input  logic        aclk,
    input  logic        aresetn,
    // fields from bit 0: codeword_index[4:0], dim_index[8:5], value[24:9]
    input  logic [31:0] s_tdata,
    // fields: req_type[0]
    input  logic        s_tuser,
    input  logic        s_tlast,
    input  logic        s_tvalid,
    output logic        s_tready,
    // fields from bit 0: nearest_index[4:0], min_distance[45:5]
    output logic [47:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NCW    = wvq_pkg::MAX_CODEWORDS;
    localparam int CW_W   = wvq_pkg::CW_W;
    localparam int DIM_W  = wvq_pkg::DIM_W;
    localparam int CF_W   = wvq_pkg::COEFF_W;
    localparam int ADDR_W = wvq_pkg::ADDR_W;
    localparam int ACC_W  = wvq_pkg::ACC_W;
    localparam int ACT_W  = wvq_pkg::ACT_W;

    // input unpacking
    logic [CW_W-1:0]  in_cw;
    logic [DIM_W-1:0] in_dim;
    logic [CF_W-1:0]  in_val;
    logic             s_acc;
    logic             dim_ok_in;

    assign in_cw     = s_tdata[CW_W-1:0];
    assign in_dim    = s_tdata[CW_W+DIM_W-1:CW_W];
    assign in_val    = s_tdata[CW_W+DIM_W+CF_W-1:CW_W+DIM_W];
    assign s_acc     = s_tvalid & s_tready;
    assign dim_ok_in = (in_dim < DIM_W'(wvq_pkg::DIMENSIONS));

    // configuration register
    logic [ACT_W-1:0] active_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite &
                    (paddr[2] == 1'(wvq_pkg::REG_ACTIVE_CODEWORDS));
    assign prdata = (paddr[2] == 1'(wvq_pkg::REG_ACTIVE_CODEWORDS)) ?
                    {{(32-ACT_W){1'b0}}, active_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= ACT_W'(32);
        end else if (cfg_wr) begin
            active_reg <= pwdata[ACT_W-1:0];
        end
    end

    // effective search count: zero means one, clamp at the codebook size
    logic [ACT_W-1:0] n_eff;
    always_comb begin
        if (active_reg == '0) begin
            n_eff = ACT_W'(1);
        end else if (active_reg > ACT_W'(NCW)) begin
            n_eff = ACT_W'(NCW);
        end else begin
            n_eff = active_reg;
        end
    end

    // latched feature element
    logic [CF_W-1:0]             feat_reg;
    logic [DIM_W-1:0]            dim_reg;
    logic                        dim_ok_reg;
    logic                        last_reg;
    logic [ACT_W-1:0]            n_reg;
    logic [wvq_pkg::WEIGHT_W-1:0] weight_reg;

    // sequencer
    logic                        issue_reg, issue_next;
    logic [CW_W-1:0]             cnt_reg,   cnt_next;
    logic                        pend_reg,  pend_next;
    logic                        mac_busy;
    logic                        feat_acc;
    wvq_pkg::wvq_tag_t           tag1_reg,  tag1_next;

    assign s_tready = aresetn & ~issue_reg & ~tag1_reg.valid & ~mac_busy & ~pend_reg;
    assign feat_acc = s_acc & (s_tuser == wvq_pkg::REQ_FEATURE);

    always_comb begin
        issue_next = issue_reg;
        cnt_next   = cnt_reg;
        tag1_next  = '0;
        if (feat_acc) begin
            issue_next = 1'b1;
            cnt_next   = '0;
        end else if (issue_reg) begin
            tag1_next.valid    = 1'b1;
            tag1_next.k        = cnt_reg;
            tag1_next.in_range = (ACT_W'(cnt_reg) < n_reg);
            tag1_next.term_en  = (ACT_W'(cnt_reg) < n_reg) & dim_ok_reg;
            cnt_next           = cnt_reg + 1'b1;
            if (cnt_reg == CW_W'(NCW - 1)) begin
                issue_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg <= 1'b0;
            cnt_reg   <= '0;
            tag1_reg  <= '0;
        end else begin
            issue_reg <= issue_next;
            cnt_reg   <= cnt_next;
            tag1_reg  <= tag1_next;
        end
        if (feat_acc) begin
            feat_reg   <= in_val;
            dim_reg    <= in_dim;
            dim_ok_reg <= dim_ok_in;
            last_reg   <= s_tlast;
            n_reg      <= n_eff;
            weight_reg <= wvq_pkg::dim_weight(in_dim);
        end
    end

    // codebook memory: written by codebook requests, read one codeword a cycle
    logic [CF_W-1:0]   cb_mem [wvq_pkg::MAX_CODEWORDS*wvq_pkg::DIMENSIONS];
    logic [CF_W-1:0]   rd_data_reg;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [DIM_W-1:0]  rd_dim;
    logic              cb_wr;

    assign cb_wr   = s_acc & (s_tuser == wvq_pkg::REQ_CODEBOOK) & dim_ok_in;
    assign wr_addr = ADDR_W'(in_cw) * ADDR_W'(wvq_pkg::DIMENSIONS) + ADDR_W'(in_dim);
    assign rd_dim  = dim_ok_reg ? dim_reg : '0;
    assign rd_addr = ADDR_W'(cnt_reg) * ADDR_W'(wvq_pkg::DIMENSIONS) + ADDR_W'(rd_dim);

    always_ff @(posedge aclk) begin
        if (cb_wr) begin
            cb_mem[wr_addr] <= in_val;
        end
        rd_data_reg <= cb_mem[rd_addr];
    end

    // weighted squared difference
    wvq_pkg::wvq_tag_t tag4;
    logic [ACC_W-1:0]  term;

    wvq_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tag_in  (tag1_reg),
        .coeff   (rd_data_reg),
        .feat    (feat_reg),
        .weight  (weight_reg),
        .tag_out (tag4),
        .term    (term),
        .busy    (mac_busy)
    );

    // accumulator ring: cell 0 always holds the codeword now at the head
    logic [ACC_W-1:0] ring [NCW];
    logic [ACC_W-1:0] head_sum_full;
    logic [ACC_W:0]   sum;
    logic [ACC_W-1:0] wb_val;

    assign sum           = {1'b0, ring[0]} + {1'b0, term};
    assign head_sum_full = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
    assign wb_val        = last_reg ? '0 : head_sum_full;

    for (genvar i = 0; i < NCW; i++) begin : g_ring
        logic [ACC_W-1:0] nb_in;
        if (i == NCW - 1) begin : g_tail
            assign nb_in = wb_val;
        end else begin : g_mid
            assign nb_in = ring[i+1];
        end
        wvq_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (tag4.valid),
            .acc_in   (nb_in),
            .acc_out  (ring[i])
        );
    end

    // running minimum over the pass; lower index wins a tie
    logic [ACC_W-1:0] best_reg, best_next;
    logic [CW_W-1:0]  bidx_reg, bidx_next;
    logic             out_free;
    logic [ACC_W-1:0] m_dist_reg;
    logic [CW_W-1:0]  m_idx_reg;
    logic             m_valid_reg, m_valid_next;

    assign out_free = ~m_valid_reg | m_tready;

    always_comb begin
        best_next    = best_reg;
        bidx_next    = bidx_reg;
        pend_next    = pend_reg;
        m_valid_next = m_valid_reg;
        if (tag4.valid && tag4.in_range &&
                ((tag4.k == '0) || (head_sum_full < best_reg))) begin
            best_next = head_sum_full;
            bidx_next = tag4.k;
        end
        if (tag4.valid && (tag4.k == CW_W'(NCW - 1)) && last_reg) begin
            pend_next = 1'b1;
        end
        if (pend_reg && out_free) begin
            pend_next    = 1'b0;
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        best_reg <= best_next;
        bidx_reg <= bidx_next;
        if (pend_reg && out_free) begin
            m_dist_reg <= best_reg;
            m_idx_reg  <= bidx_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(48-ACC_W-CW_W){1'b0}}, m_dist_reg, m_idx_reg};

    // no request is taken while a pass is in flight
    a_idle_when_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!issue_reg && !tag1_reg.valid && !tag4.valid))
        else $error("input ready during a search pass");

    // a pending result is kept until the output register frees
    a_pend_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg && !out_free) |=> pend_reg)
        else $error("pending result lost");

    // the chosen codeword lies within the searched range
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (tag4.valid && tag4.k == CW_W'(NCW - 1)) |=> (ACT_W'(bidx_reg) < n_reg))
        else $error("nearest index outside the active codewords");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for weighted_vq_nearest_codeword: streams codebook and feature
// requests, predicts each nearest-codeword result and checks the result stream.
// Depends on wvq_pkg and the RTL top level only.
module tb_top;

    localparam int          RANDOM_ITEMS   = 650;
    localparam int          SETTLE_CYCLES  = 64;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam logic [63:0] ACC_LIMIT      = (64'd1 << wvq_pkg::ACC_W) - 64'd1;
    localparam int unsigned DIM_WEIGHTS [12] = '{1, 3, 7, 13, 19, 22, 25, 33, 42, 50, 56, 61};

    typedef struct packed {
        logic        req;
        logic [4:0]  cw;
        logic [3:0]  dim;
        logic [15:0] value;
        logic        last;
    } vq_request_t;

    typedef struct packed {
        logic [4:0]                idx;
        logic [wvq_pkg::ACC_W-1:0] distance;
    } vq_result_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic [31:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    weighted_vq_nearest_codeword dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),   // from bit 0: codeword_index[4:0], dim_index[8:5], value[24:9]
        .s_tuser  (s_tuser),   // req_type[0]
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),   // from bit 0: nearest_index[4:0], min_distance[45:5]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // shadow copy of the block state
    logic [15:0]               codebook_copy [wvq_pkg::MAX_CODEWORDS*wvq_pkg::DIMENSIONS];
    logic [wvq_pkg::ACC_W-1:0] distance_acc  [wvq_pkg::MAX_CODEWORDS];
    logic [5:0]                active_count;
    vq_result_t                awaited_nearest [$];

    bit          no_idle = 1'b0;
    int unsigned rx_hold = 0;
    int          mismatches = 0;
    int          requests_sent = 0;
    int          idle_cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned pick_gap();
        return no_idle ? 0 : $urandom_range(0, 19);
    endfunction

    // mostly extremes and small values, so that ties and saturation both occur
    function automatic logic [15:0] rand_coeff();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2, 3, 4: return 16'($urandom_range(0, 8) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    // update the shadow state with one accepted request, queue any result
    function automatic void model_request(input vq_request_t r);
        int unsigned n;
        int unsigned k;
        int unsigned entry;
        logic signed [16:0] diff;
        logic [16:0] mag;
        logic [63:0] term;
        logic [63:0] sum;
        vq_result_t  best;
        if (r.req == wvq_pkg::REQ_CODEBOOK) begin
            if (r.dim < wvq_pkg::DIMENSIONS)
                codebook_copy[r.cw*wvq_pkg::DIMENSIONS + r.dim] = r.value;
            return;
        end
        n = (active_count == 0) ? 1 :
            (active_count > wvq_pkg::MAX_CODEWORDS) ? wvq_pkg::MAX_CODEWORDS : active_count;
        if (r.dim < wvq_pkg::DIMENSIONS) begin
            for (k = 0; k < n; k++) begin
                entry = k*wvq_pkg::DIMENSIONS + r.dim;
                diff = $signed({codebook_copy[entry][15], codebook_copy[entry]})
                     - $signed({r.value[15], r.value});
                mag  = (diff < 0) ? 17'(-diff) : 17'(diff);
                term = 64'(DIM_WEIGHTS[r.dim]) * 64'(mag) * 64'(mag);
                sum  = 64'(distance_acc[k]);
                if (term > ACC_LIMIT - sum)
                    distance_acc[k] = ACC_LIMIT[wvq_pkg::ACC_W-1:0];
                else
                    distance_acc[k] = wvq_pkg::ACC_W'(sum + term);
            end
        end
        if (!r.last)
            return;
        best.idx      = '0;
        best.distance = distance_acc[0];
        for (k = 1; k < n; k++) begin
            if (distance_acc[k] < best.distance) begin
                best.distance = distance_acc[k];
                best.idx      = 5'(k);
            end
        end
        for (k = 0; k < wvq_pkg::MAX_CODEWORDS; k++)
            distance_acc[k] = '0;
        awaited_nearest = {awaited_nearest, best};
    endfunction

    // one request on the input stream; valid stays up for a back-to-back follower
    task automatic send_request(input vq_request_t r);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {7'd0, r.value, r.dim, r.cw};
        s_tuser  <= r.req;
        s_tlast  <= r.last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        model_request(r);
        requests_sent++;
    endtask

    task automatic send_codebook(input logic [4:0] cw, input logic [3:0] dim,
                                 input logic [15:0] value, input logic last);
        send_request('{wvq_pkg::REQ_CODEBOOK, cw, dim, value, last});
    endtask

    task automatic send_feature(input logic [3:0] dim, input logic [15:0] value,
                                input logic last);
        send_request('{wvq_pkg::REQ_FEATURE, 5'($urandom), dim, value, last});
    endtask

    // stop sending, let every awaited result arrive and the pipeline settle
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (awaited_nearest.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_active_count(input logic [5:0] count);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4*wvq_pkg::REG_ACTIVE_CODEWORDS);
        pwdata  <= 32'(count);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        active_count = count;
    endtask

    task automatic send_full_vector();
        logic [3:0] order [wvq_pkg::DIMENSIONS];
        logic [3:0] swap;
        int i;
        int j;
        for (i = 0; i < wvq_pkg::DIMENSIONS; i++)
            order[i] = 4'(i);
        for (i = wvq_pkg::DIMENSIONS-1; i > 0; i--) begin
            j = $urandom_range(0, i);
            swap = order[i];
            order[i] = order[j];
            order[j] = swap;
        end
        for (i = 0; i < wvq_pkg::DIMENSIONS; i++)
            send_feature(order[i], rand_coeff(), i == wvq_pkg::DIMENSIONS-1);
    endtask

    // whole codebook written first so that no search reads an unwritten entry
    task automatic load_codebook();
        int c;
        int d;
        for (c = 0; c < wvq_pkg::MAX_CODEWORDS; c++)
            for (d = 0; d < wvq_pkg::DIMENSIONS; d++)
                send_codebook(5'(c), 4'(d), rand_coeff(), 1'b0);
    endtask

    // reset count of 32, feature values at both extremes
    task automatic test_default_count();
        int d;
        for (d = 0; d < wvq_pkg::DIMENSIONS; d++)
            send_feature(4'(d), d[0] ? 16'h7FFF : 16'h8000, d == wvq_pkg::DIMENSIONS-1);
    endtask

    // zero counts as one, above 32 saturates
    task automatic test_count_limits();
        logic [5:0] counts [6] = '{6'd0, 6'd1, 6'd2, 6'd31, 6'd33, 6'd63};
        int i;
        for (i = 0; i < 6; i++) begin
            wait_for_results();
            write_active_count(counts[i]);
            send_feature(4'($urandom_range(0, 11)), rand_coeff(), 1'b0);
            send_feature(4'($urandom_range(0, 11)), rand_coeff(), 1'b1);
        end
    endtask

    // dims out of range, last on a codebook write, a repeated dim
    task automatic test_special_cases();
        wait_for_results();
        write_active_count(6'd32);
        send_feature(4'd5, rand_coeff(), 1'b0);
        send_codebook(5'd7, 4'd12, 16'h1234, 1'b1);
        send_codebook(5'd31, 4'd15, 16'hFFFF, 1'b0);
        send_feature(4'd13, 16'h7FFF, 1'b0);
        send_feature(4'd5, rand_coeff(), 1'b0);
        send_feature(4'd14, 16'h8000, 1'b1);
        send_feature(4'd15, rand_coeff(), 1'b1);
    endtask

    // equal distances keep the lower index
    task automatic test_tie();
        logic [15:0] v;
        v = rand_coeff();
        wait_for_results();
        write_active_count(6'd2);
        send_codebook(5'd0, 4'd0, v, 1'b0);
        send_codebook(5'd1, 4'd0, v, 1'b0);
        send_feature(4'd0, rand_coeff(), 1'b1);
    endtask

    // nine largest terms at the heaviest weight overflow 41 bits
    task automatic test_saturation();
        int i;
        send_codebook(5'd0, 4'd11, 16'h8000, 1'b0);
        send_codebook(5'd1, 4'd11, 16'h8000, 1'b0);
        for (i = 0; i < 9; i++)
            send_feature(4'd11, 16'h7FFF, i == 8);
    endtask

    // mostly complete vectors in random order, with noise between them
    task automatic test_random();
        logic [5:0] counts [6];
        int phase;
        int target;
        int len;
        int i;
        counts = '{6'd32, 6'd1, 6'($urandom_range(2, 31)), 6'd0,
                   6'($urandom_range(33, 63)), 6'($urandom_range(2, 32))};
        target = requests_sent;
        for (phase = 0; phase < 6; phase++) begin
            wait_for_results();
            write_active_count(counts[phase]);
            target += RANDOM_ITEMS / 6;
            while (requests_sent < target) begin
                no_idle = ($urandom_range(0, 4) == 0);
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4: begin
                        len = $urandom_range(1, 4);
                        for (i = 0; i < len; i++)
                            send_feature(4'($urandom_range(0, 15)), rand_coeff(),
                                         i == len-1);
                    end
                    5, 6, 7: begin
                        len = $urandom_range(1, 6);
                        for (i = 0; i < len; i++)
                            send_codebook(5'($urandom), 4'($urandom_range(0, 15)),
                                          rand_coeff(), 1'($urandom));
                    end
                    default: send_full_vector();
                endcase
            end
        end
        no_idle = 1'b0;
    endtask

    // result side: random stall before each result
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold = 0;
        end else if (m_tvalid && m_tready) begin
            rx_hold = pick_gap();
            m_tready <= (rx_hold == 0);
        end else if (!m_tready) begin
            if (rx_hold > 1) begin
                rx_hold--;
            end else begin
                rx_hold = 0;
                m_tready <= 1'b1;
            end
        end
    end

    // compare each accepted result with the oldest awaited one
    always @(posedge aclk) begin
        vq_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_nearest.size() == 0) begin
                $display("%0t: unexpected result, expected none, got index %0d distance %0d",
                         $time, m_tdata[4:0], m_tdata[45:5]);
                mismatches++;
            end else begin
                want = awaited_nearest.pop_front();
                if (m_tdata[4:0] !== want.idx) begin
                    $display("%0t: nearest_index expected %0d got %0d",
                             $time, want.idx, m_tdata[4:0]);
                    mismatches++;
                end
                if (m_tdata[45:5] !== want.distance) begin
                    $display("%0t: min_distance expected %0d got %0d",
                             $time, want.distance, m_tdata[45:5]);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted request, result or register write
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (psel && penable && pwrite && pready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        int k;
        active_count = 6'd32;
        for (k = 0; k < wvq_pkg::MAX_CODEWORDS; k++)
            distance_acc[k] = '0;
        for (k = 0; k < wvq_pkg::MAX_CODEWORDS*wvq_pkg::DIMENSIONS; k++)
            codebook_copy[k] = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        load_codebook();
        test_default_count();
        test_count_limits();
        test_special_cases();
        test_tie();
        test_saturation();
        test_random();
        wait_for_results();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
